// File: design/assert_macros.svh
// Assertion helpers; clocked on aclk, off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define AST_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: design/ladrc_pkg.sv
package ladrc_pkg;

    localparam int FRAC_BITS = 32;

    localparam logic signed [63:0] MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM  = 64'sd2000 <<< FRAC_BITS;

    // register indexes (word address)
    localparam logic [2:0] REG_STEP_SIZE  = 3'd0;
    localparam logic [2:0] REG_TRACK_SPD  = 3'd1;
    localparam logic [2:0] REG_CTRL_BW    = 3'd2;
    localparam logic [2:0] REG_OBS_BW     = 3'd3;
    localparam logic [2:0] REG_PLANT_GAIN = 3'd4;

    localparam logic [5:0] PROG_LAST = 6'd40;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MULF, OP_MUL32, OP_DIV
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_TP, SRC_TR, SRC_OP, SRC_ORATE, SRC_OD, SRC_LD,
        SRC_SP, SRC_Y, SRC_R, SRC_WC, SRC_W0, SRC_B0, SRC_H,
        SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4
    } src_t;

    typedef enum logic [3:0] {
        DST_TP, DST_TR, DST_OP, DST_ORATE, DST_OD, DST_LD,
        DST_T0, DST_T1, DST_T2, DST_T3, DST_T4
    } dst_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t d;
    } uop_t;

    typedef struct packed {
        logic start;
        uop_t uop;
        logic load_in;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_stat_t;

    function automatic uop_t mk(input op_t o, input src_t a, input src_t b, input dst_t d);
        uop_t u;
        u.op = o;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // one control step as a micro program
    function automatic uop_t prog(input logic [5:0] pc);
        uop_t u;
        case (pc)
            // tracking differentiator
            6'd0:  u = mk(OP_MULF,  SRC_R,     SRC_R,     DST_T0);
            6'd1:  u = mk(OP_SUB,   SRC_TP,    SRC_SP,    DST_T1);
            6'd2:  u = mk(OP_MULF,  SRC_T0,    SRC_T1,    DST_T0);
            6'd3:  u = mk(OP_SUB,   SRC_ZERO,  SRC_T0,    DST_T0);
            6'd4:  u = mk(OP_ADD,   SRC_R,     SRC_R,     DST_T1);
            6'd5:  u = mk(OP_MULF,  SRC_T1,    SRC_TR,    DST_T1);
            6'd6:  u = mk(OP_SUB,   SRC_T0,    SRC_T1,    DST_T0);
            6'd7:  u = mk(OP_MUL32, SRC_TR,    SRC_H,     DST_T1);
            6'd8:  u = mk(OP_ADD,   SRC_TP,    SRC_T1,    DST_TP);
            6'd9:  u = mk(OP_MUL32, SRC_T0,    SRC_H,     DST_T0);
            6'd10: u = mk(OP_ADD,   SRC_TR,    SRC_T0,    DST_TR);
            // observer gains
            6'd11: u = mk(OP_ADD,   SRC_W0,    SRC_W0,    DST_T0);
            6'd12: u = mk(OP_ADD,   SRC_T0,    SRC_W0,    DST_T0);
            6'd13: u = mk(OP_MULF,  SRC_W0,    SRC_W0,    DST_T1);
            6'd14: u = mk(OP_ADD,   SRC_T1,    SRC_T1,    DST_T2);
            6'd15: u = mk(OP_ADD,   SRC_T2,    SRC_T1,    DST_T2);
            6'd16: u = mk(OP_MULF,  SRC_T1,    SRC_W0,    DST_T1);
            // observer update
            6'd17: u = mk(OP_SUB,   SRC_OP,    SRC_Y,     DST_T3);
            6'd18: u = mk(OP_MULF,  SRC_T0,    SRC_T3,    DST_T0);
            6'd19: u = mk(OP_SUB,   SRC_ORATE, SRC_T0,    DST_T0);
            6'd20: u = mk(OP_MUL32, SRC_T0,    SRC_H,     DST_T0);
            6'd21: u = mk(OP_ADD,   SRC_OP,    SRC_T0,    DST_OP);
            6'd22: u = mk(OP_MULF,  SRC_T2,    SRC_T3,    DST_T2);
            6'd23: u = mk(OP_SUB,   SRC_OD,    SRC_T2,    DST_T2);
            6'd24: u = mk(OP_MULF,  SRC_B0,    SRC_LD,    DST_T4);
            6'd25: u = mk(OP_ADD,   SRC_T2,    SRC_T4,    DST_T2);
            6'd26: u = mk(OP_MUL32, SRC_T2,    SRC_H,     DST_T2);
            6'd27: u = mk(OP_ADD,   SRC_ORATE, SRC_T2,    DST_ORATE);
            6'd28: u = mk(OP_MULF,  SRC_T1,    SRC_T3,    DST_T1);
            6'd29: u = mk(OP_SUB,   SRC_ZERO,  SRC_T1,    DST_T1);
            6'd30: u = mk(OP_MUL32, SRC_T1,    SRC_H,     DST_T1);
            6'd31: u = mk(OP_ADD,   SRC_OD,    SRC_T1,    DST_OD);
            // feedback law
            6'd32: u = mk(OP_MULF,  SRC_WC,    SRC_WC,    DST_T0);
            6'd33: u = mk(OP_ADD,   SRC_WC,    SRC_WC,    DST_T1);
            6'd34: u = mk(OP_SUB,   SRC_TP,    SRC_OP,    DST_T2);
            6'd35: u = mk(OP_SUB,   SRC_TR,    SRC_ORATE, DST_T3);
            6'd36: u = mk(OP_MULF,  SRC_T0,    SRC_T2,    DST_T0);
            6'd37: u = mk(OP_MULF,  SRC_T1,    SRC_T3,    DST_T1);
            6'd38: u = mk(OP_ADD,   SRC_T0,    SRC_T1,    DST_T0);
            6'd39: u = mk(OP_SUB,   SRC_T0,    SRC_OD,    DST_T0);
            6'd40: u = mk(OP_DIV,   SRC_T0,    SRC_ZERO,  DST_LD);
            default: u = mk(OP_ADD, SRC_ZERO,  SRC_ZERO,  DST_T4);
        endcase
        return u;
    endfunction

endpackage

// File: design/linear_adrc_controller_top.sv
// Linear ADRC controller, one control step per input transfer.
// Input stream (s_*): s_tdata carries setpoint and measurement, both signed
// Q15.16. Output stream (m_*): m_tdata carries the drive, signed Q11.16,
// limited to +/-2000; m_tuser flags that the limit was hit.
// Gains and the sample period sit in APB registers at byte address 4*i:
// step size, tracking speed, controller bandwidth, observer bandwidth,
// plant gain. Write them only while the block is idle.
// One shared ALU runs a 41-op program: a 64x64 multiply is four 32x32
// partial products, then round, and the final divide by b0 is bit
// serial. No new input is taken while a step runs; the next input is
// taken while a result still waits in the output register.
// Reset (synchronous, active low) clears all loop state and returns the
// config registers to their defaults. When the receiver stalls, the
// finished result holds in the output register; a following step runs
// to completion and then waits for that slot before it is written.
module linear_adrc_controller_top
    import ladrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] setpoint, [63:32] measurement
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [27:0] drive, [31:28] zero
    output logic        m_tuser,   // [0] clamped
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [28:0] step_size_reg;
    logic [26:0] track_spd_reg, ctrl_bw_reg, obs_bw_reg, plant_gain_reg;
    logic        cfg_wr;
    logic [27:0] drive;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // config registers; out-of-range bits of a write are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= 29'd4294967;
            track_spd_reg  <= 27'd1310720;
            ctrl_bw_reg    <= 27'd2162688;
            obs_bw_reg     <= 27'd8716288;
            plant_gain_reg <= 27'd524288;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_STEP_SIZE:  step_size_reg  <= pwdata[28:0];
                REG_TRACK_SPD:  track_spd_reg  <= pwdata[26:0];
                REG_CTRL_BW:    ctrl_bw_reg    <= pwdata[26:0];
                REG_OBS_BW:     obs_bw_reg     <= pwdata[26:0];
                REG_PLANT_GAIN: plant_gain_reg <= pwdata[26:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_STEP_SIZE:  prdata = 32'(step_size_reg);
            REG_TRACK_SPD:  prdata = 32'(track_spd_reg);
            REG_CTRL_BW:    prdata = 32'(ctrl_bw_reg);
            REG_OBS_BW:     prdata = 32'(obs_bw_reg);
            REG_PLANT_GAIN: prdata = 32'(plant_gain_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer: accepts transfers, steps through the program
    ladrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // shared ALU, multiplier, divider and loop state
    ladrc_dpath u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .setpoint             (s_tdata[31:0]),
        .measurement          (s_tdata[63:32]),
        .step_size            (step_size_reg),
        .tracking_speed       (track_spd_reg),
        .controller_bandwidth (ctrl_bw_reg),
        .observer_bandwidth   (obs_bw_reg),
        .plant_gain           (plant_gain_reg),
        .drive                (drive),
        .clamped              (m_tuser)
    );

    assign m_tdata = {4'd0, drive};

endmodule

// File: design/ladrc_ctrl.sv
module ladrc_ctrl
    import ladrc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);
`include "assert_macros.svh"

    state_t     state_reg, state_next;
    logic [5:0] pc_reg, pc_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pc_next    = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (stat.done) begin
                    if (pc_reg == PROG_LAST) begin
                        state_next = ST_OUT;
                    end else begin
                        pc_next    = pc_reg + 6'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cmd.start    = (state_reg == ST_ISSUE);
        cmd.uop      = prog(pc_reg);
        cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
        m_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `AST_IMPLY(a_start_free, cmd.start, !stat.busy, "op issued while datapath busy")
    `AST_IMPLY(a_done_wait, stat.done, state_reg == ST_WAIT, "datapath done outside wait")
    `AST_ALWAYS(a_pc_range, pc_reg <= PROG_LAST, "program counter out of range")

endmodule

// File: design/ladrc_dpath.sv
module ladrc_dpath
    import ladrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [31:0] setpoint,
    input  logic [31:0] measurement,
    input  logic [28:0] step_size,
    input  logic [26:0] tracking_speed,
    input  logic [26:0] controller_bandwidth,
    input  logic [26:0] observer_bandwidth,
    input  logic [26:0] plant_gain,
    output logic [27:0] drive,
    output logic        clamped
);

    localparam logic signed [64:0] MAXV65 = 65'(MAXV);
    localparam logic signed [64:0] MINV65 = -MAXV65;
    localparam int PS = FRAC_BITS - 16;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
        logic signed [63:0] v;
        if (s > MAXV65) v = MAXV;
        else if (s < MINV65) v = -MAXV;
        else v = s[63:0];
        return v;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? (~x + 64'd1) : x;
        return m;
    endfunction

    function automatic logic signed [63:0] smag(input logic [63:0] m, input logic neg);
        logic signed [63:0] v;
        v = (m > 64'(MAXV)) ? MAXV : $signed(m);
        return neg ? -v : v;
    endfunction

    // loop state and temporaries
    logic signed [63:0] tp_reg, tr_reg, op_reg, orate_reg, od_reg, ld_reg;
    logic signed [63:0] tp_next, tr_next, op_next, orate_next, od_next, ld_next;
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [63:0] t0_next, t1_next, t2_next, t3_next, t4_next;
    logic signed [63:0] sp_reg, y_reg, sp_next, y_next;

    // execution unit
    logic signed [63:0] opa_reg, opb_reg, opa_next, opb_next;
    op_t                kind_reg, kind_next;
    dst_t               dst_reg, dst_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [63:0]        ma_reg, mb_reg, ma_next, mb_next;
    logic               neg_reg, neg_next, zero_reg, zero_next;
    logic [127:0]       acc_reg, acc_next;
    logic [127:0]       num_reg, num_next;
    logic [27:0]        rem_reg, rem_next;
    logic [63:0]        q_reg, q_next;
    logic               over_reg, over_next;
    logic               clip_reg, clip_next;
    logic [27:0]        drive_reg, drive_next;
    logic               clamped_reg, clamped_next;

    logic signed [63:0] src_a, src_b, res, u;
    logic               wr, done;
    logic [31:0]        pa, pb;
    logic [63:0]        pp;
    logic [127:0]       pp_sh, rnd, shd;
    logic [28:0]        rs;
    logic               ge;
    logic [63:0]        qr, om;

    function automatic logic signed [63:0] pick(
        input src_t s, input logic signed [63:0] tp, input logic signed [63:0] tr,
        input logic signed [63:0] opv, input logic signed [63:0] orv,
        input logic signed [63:0] od, input logic signed [63:0] ld,
        input logic signed [63:0] sp, input logic signed [63:0] y,
        input logic signed [63:0] r, input logic signed [63:0] wc,
        input logic signed [63:0] w0, input logic signed [63:0] b0,
        input logic signed [63:0] h, input logic signed [63:0] t0,
        input logic signed [63:0] t1, input logic signed [63:0] t2,
        input logic signed [63:0] t3, input logic signed [63:0] t4);
        logic signed [63:0] v;
        case (s)
            SRC_TP:    v = tp;
            SRC_TR:    v = tr;
            SRC_OP:    v = opv;
            SRC_ORATE: v = orv;
            SRC_OD:    v = od;
            SRC_LD:    v = ld;
            SRC_SP:    v = sp;
            SRC_Y:     v = y;
            SRC_R:     v = r;
            SRC_WC:    v = wc;
            SRC_W0:    v = w0;
            SRC_B0:    v = b0;
            SRC_H:     v = h;
            SRC_T0:    v = t0;
            SRC_T1:    v = t1;
            SRC_T2:    v = t2;
            SRC_T3:    v = t3;
            SRC_T4:    v = t4;
            default:   v = '0;
        endcase
        return v;
    endfunction

    logic signed [63:0] r_int, wc_int, w0_int, b0_int, h_int;
    assign r_int  = $signed(64'(tracking_speed) << PS);
    assign wc_int = $signed(64'(controller_bandwidth) << PS);
    assign w0_int = $signed(64'(observer_bandwidth) << PS);
    assign b0_int = $signed(64'(plant_gain) << PS);
    assign h_int  = $signed(64'(step_size));

    assign src_a = pick(cmd.uop.a, tp_reg, tr_reg, op_reg, orate_reg, od_reg, ld_reg,
                        sp_reg, y_reg, r_int, wc_int, w0_int, b0_int, h_int,
                        t0_reg, t1_reg, t2_reg, t3_reg, t4_reg);
    assign src_b = pick(cmd.uop.b, tp_reg, tr_reg, op_reg, orate_reg, od_reg, ld_reg,
                        sp_reg, y_reg, r_int, wc_int, w0_int, b0_int, h_int,
                        t0_reg, t1_reg, t2_reg, t3_reg, t4_reg);

    always_comb begin
        opa_next  = opa_reg;  opb_next = opb_reg;
        kind_next = kind_reg; dst_next = dst_reg;
        cnt_next  = cnt_reg;  busy_next = busy_reg;
        ma_next   = ma_reg;   mb_next  = mb_reg;
        neg_next  = neg_reg;  zero_next = zero_reg;
        acc_next  = acc_reg;  num_next = num_reg;
        rem_next  = rem_reg;  q_next   = q_reg;
        over_next = over_reg; clip_next = clip_reg;
        res = '0; wr = 1'b0; done = 1'b0; u = '0;

        // 32x32 partial product, one per cycle
        pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        case (cnt_reg[1:0])
            2'd0:    pp_sh = 128'(pp);
            2'd3:    pp_sh = 128'(pp) << 64;
            default: pp_sh = 128'(pp) << 32;
        endcase
        if (kind_reg == OP_MULF) begin
            rnd = acc_reg + (128'd1 << (FRAC_BITS - 1));
            shd = rnd >> FRAC_BITS;
        end else begin
            rnd = acc_reg + (128'd1 << 31);
            shd = rnd >> 32;
        end

        // restoring divide step
        rs = {rem_reg, num_reg[127]};
        ge = rs >= 29'(plant_gain);
        qr = q_reg + (({rem_reg, 1'b0} >= 29'(plant_gain)) ? 64'd1 : 64'd0);

        if (cmd.start) begin
            opa_next  = src_a;
            opb_next  = src_b;
            kind_next = cmd.uop.op;
            dst_next  = cmd.uop.d;
            cnt_next  = '0;
            busy_next = 1'b1;
            ma_next   = mag64(src_a);
            mb_next   = mag64(src_b);
            neg_next  = (cmd.uop.op == OP_DIV) ? src_a[63] : (src_a[63] ^ src_b[63]);
            zero_next = (src_a == 64'sd0);
            acc_next  = '0;
            num_next  = {48'd0, mag64(src_a), 16'd0};
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
        end else if (busy_reg) begin
            case (kind_reg)
                OP_ADD: begin
                    res = sat65(65'(opa_reg) + 65'(opb_reg));
                    wr = 1'b1; done = 1'b1; busy_next = 1'b0;
                end
                OP_SUB: begin
                    res = sat65(65'(opa_reg) - 65'(opb_reg));
                    wr = 1'b1; done = 1'b1; busy_next = 1'b0;
                end
                OP_MULF, OP_MUL32: begin
                    if (cnt_reg[2]) begin
                        res = (shd[127:64] != 64'd0) ? (neg_reg ? -MAXV : MAXV)
                                                     : smag(shd[63:0], neg_reg);
                        wr = 1'b1; done = 1'b1; busy_next = 1'b0;
                    end else begin
                        acc_next = acc_reg + pp_sh;
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
                OP_DIV: begin
                    if (cnt_reg[7]) begin
                        if (zero_reg) u = '0;
                        else if (over_reg) u = neg_reg ? -MAXV : MAXV;
                        else u = smag(qr, neg_reg);
                        if (u > LIM) begin
                            res = LIM; clip_next = 1'b1;
                        end else if (u < -LIM) begin
                            res = -LIM; clip_next = 1'b1;
                        end else begin
                            res = u; clip_next = 1'b0;
                        end
                        wr = 1'b1; done = 1'b1; busy_next = 1'b0;
                    end else begin
                        // quotient bits at or above 63 mean overflow
                        if (ge && cnt_reg <= 8'd64) over_next = 1'b1;
                        rem_next = ge ? 28'(rs - 29'(plant_gain)) : rs[27:0];
                        q_next   = {q_reg[62:0], ge && (cnt_reg > 8'd64)};
                        num_next = num_reg << 1;
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
                default: begin
                    done = 1'b1; busy_next = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        tp_next = tp_reg; tr_next = tr_reg; op_next = op_reg;
        orate_next = orate_reg; od_next = od_reg; ld_next = ld_reg;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg;
        t3_next = t3_reg; t4_next = t4_reg;
        if (wr) begin
            case (dst_reg)
                DST_TP:    tp_next = res;
                DST_TR:    tr_next = res;
                DST_OP:    op_next = res;
                DST_ORATE: orate_next = res;
                DST_OD:    od_next = res;
                DST_LD:    ld_next = res;
                DST_T0:    t0_next = res;
                DST_T1:    t1_next = res;
                DST_T2:    t2_next = res;
                DST_T3:    t3_next = res;
                DST_T4:    t4_next = res;
                default:   t4_next = t4_reg;
            endcase
        end
        sp_next = cmd.load_in ? (64'(signed'(setpoint)) <<< PS) : sp_reg;
        y_next  = cmd.load_in ? (64'(signed'(measurement)) <<< PS) : y_reg;
        // port format, rounded half away from zero
        om = (mag64(ld_reg) + (64'd1 << (PS - 1))) >> PS;
        drive_next   = cmd.load_out ? (ld_reg[63] ? 28'(-om) : 28'(om)) : drive_reg;
        clamped_next = cmd.load_out ? clip_reg : clamped_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg <= '0; tr_reg <= '0; op_reg <= '0;
            orate_reg <= '0; od_reg <= '0; ld_reg <= '0;
            busy_reg <= 1'b0;
            clip_reg <= 1'b0;
        end else begin
            tp_reg <= tp_next; tr_reg <= tr_next; op_reg <= op_next;
            orate_reg <= orate_next; od_reg <= od_next; ld_reg <= ld_next;
            busy_reg <= busy_next;
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge aclk) begin
        t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next;
        t3_reg <= t3_next; t4_reg <= t4_next;
        sp_reg <= sp_next; y_reg <= y_next;
        opa_reg <= opa_next; opb_reg <= opb_next;
        kind_reg <= kind_next; dst_reg <= dst_next; cnt_reg <= cnt_next;
        ma_reg <= ma_next; mb_reg <= mb_next;
        neg_reg <= neg_next; zero_reg <= zero_next;
        acc_reg <= acc_next; num_reg <= num_next;
        rem_reg <= rem_next; q_reg <= q_next; over_reg <= over_next;
        drive_reg <= drive_next; clamped_reg <= clamped_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

endmodule
